[rtl/mer_pkg.sv]
// shared constants and types of the midpoint ellipse rasterizer
`default_nettype none

package mer_pkg;

  // default coordinate width of centers and offsets
  localparam int COORD_BITS_DEF = 12;

  // depth of the request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // points emitted for one step of the outline
  localparam int PTS_PER_STEP = 4;

  // command codes on the input channel
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // classified operation handed from front to back
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // control of one result group handed from back to emitter
  typedef struct packed {
    logic points;
    logic done;
  } grp_t;

endpackage

`default_nettype wire

[rtl/mer_if.sv]
// request and pixel channel interfaces of the midpoint ellipse rasterizer
`default_nettype none

interface mer_cmd_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-2:0] radius_x;
  logic [COORD_BITS-2:0] radius_y;

  modport source (
    output valid, command, center_x, center_y, radius_x, radius_y,
    input  ready
  );
  modport sink (
    input  valid, command, center_x, center_y, radius_x, radius_y,
    output ready
  );
endinterface

interface mer_pix_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic                         pixel_valid;
  logic                         run_last;
  logic                         curve_done;

  modport source (
    output valid, pixel_x, pixel_y, pixel_valid, run_last, curve_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_valid, run_last, curve_done,
    output ready
  );
endinterface

`default_nettype wire

[rtl/mer_front.sv]
// front end: accepts requests, classifies them and queues them for the back end
`default_nettype none

module mer_front #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  mer_cmd_if.sink               cmd,
  output logic                  q_valid,
  input  logic                  q_pop,
  output mer_pkg::op_t          q_op,
  output logic [COORD_BITS-1:0] q_cx,
  output logic [COORD_BITS-1:0] q_cy,
  output logic [COORD_BITS-2:0] q_rx,
  output logic [COORD_BITS-2:0] q_ry
);

  localparam int DEPTH = mer_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RAD_W = COORD_BITS - 1;

  mer_pkg::op_t          op_q [DEPTH];
  logic [COORD_BITS-1:0] cx_q [DEPTH];
  logic [COORD_BITS-1:0] cy_q [DEPTH];
  logic [RAD_W-1:0]      rx_q [DEPTH];
  logic [RAD_W-1:0]      ry_q [DEPTH];

  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  mer_pkg::op_t     op_in;

  // classify the incoming command code
  always_comb begin
    case (cmd.command)
      mer_pkg::CMD_START: op_in = mer_pkg::OP_START;
      mer_pkg::CMD_STEP:  op_in = mer_pkg::OP_STEP;
      default:            op_in = mer_pkg::OP_STEP;
    endcase
  end

  assign cmd.ready = (count != CNT_W'(DEPTH));
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;

  // head of queue
  assign q_op = op_q[rptr];
  assign q_cx = cx_q[rptr];
  assign q_cy = cy_q[rptr];
  assign q_rx = rx_q[rptr];
  assign q_ry = ry_q[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      op_q[wptr] <= op_in;
      cx_q[wptr] <= cmd.center_x;
      cy_q[wptr] <= cmd.center_y;
      rx_q[wptr] <= cmd.radius_x;
      ry_q[wptr] <= cmd.radius_y;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/mer_back.sv]
// back end: decision sequencer with a shared multiplier, walks the outline
`default_nettype none

module mer_back #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  mer_pkg::op_t                 q_op,
  input  logic [COORD_BITS-1:0]        q_cx,
  input  logic [COORD_BITS-1:0]        q_cy,
  input  logic [COORD_BITS-2:0]        q_rx,
  input  logic [COORD_BITS-2:0]        q_ry,
  output logic                         grp_valid,
  input  logic                         grp_ready,
  output mer_pkg::grp_t                grp,
  output logic [COORD_BITS-1:0]        grp_cx,
  output logic [COORD_BITS-1:0]        grp_cy,
  output logic [COORD_BITS-1:0]        grp_x,
  output logic signed [COORD_BITS-1:0] grp_y
);

  localparam int CB     = COORD_BITS;
  localparam int RAD_W  = CB - 1;
  localparam int SQ_W   = 2 * RAD_W;
  localparam int AB_W   = 2 * SQ_W;
  localparam int TMP_W  = 2 * CB + 2;
  localparam int MUL_W  = TMP_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DEC_W  = 4 * CB + 2;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_MUL     = 5'b00010,
    ST_WB      = 5'b00100,
    ST_SETTLE  = 5'b01000,
    ST_DELIVER = 5'b10000
  } state_t;

  // multiply program: ellipse setup, then region two entry
  typedef enum logic [3:0] {
    U_ASQ = 4'd0,
    U_BSQ = 4'd1,
    U_T   = 4'd2,
    U_P   = 4'd3,
    U_AB  = 4'd4,
    U_TY  = 4'd5,
    U_S1  = 4'd6,
    U_Q1  = 4'd7,
    U_S2  = 4'd8,
    U_Q2  = 4'd9
  } uop_t;

  state_t state;
  uop_t   uop;
  logic   from_step;
  logic   active;
  logic   r2;

  logic [CB-1:0]          cx;
  logic [CB-1:0]          cy;
  logic [RAD_W-1:0]       rad_a;
  logic [RAD_W-1:0]       rad_b;
  logic [SQ_W-1:0]        asq;
  logic [SQ_W-1:0]        bsq;
  logic [AB_W-1:0]        absq;
  logic [TMP_W-1:0]       tmp;
  logic signed [PROD_W-1:0] prod;
  logic [CB-1:0]          x;
  logic signed [CB-1:0]   y;
  logic signed [DEC_W-1:0] d;
  logic signed [DEC_W-1:0] tx;
  logic signed [DEC_W-1:0] ty;
  mer_pkg::grp_t          gctl;
  logic [CB-1:0]          gx;
  logic signed [CB-1:0]   gy;

  logic signed [MUL_W-1:0] opa;
  logic signed [MUL_W-1:0] opb;
  logic signed [MUL_W-1:0] y_ext;
  logic signed [MUL_W-1:0] y_m1;
  logic signed [MUL_W-1:0] twob_m1;
  logic signed [MUL_W-1:0] twox_p1;

  logic signed [DEC_W-1:0] asq_d;
  logic signed [DEC_W-1:0] bsq_d;
  logic signed [DEC_W-1:0] ab_d;
  logic signed [DEC_W-1:0] prod_d;
  logic signed [DEC_W-1:0] tx_inc;
  logic signed [DEC_W-1:0] ty_dec;
  logic signed [DEC_W-1:0] lhs;
  logic signed [DEC_W-1:0] rhs;
  logic                    test_r1;
  logic                    y_neg;

  logic [CB-1:0]           x_inc;
  logic signed [CB-1:0]    y_dec;
  logic [CB-1:0]           adv_x;
  logic signed [CB-1:0]    adv_y;
  logic signed [DEC_W-1:0] adv_d;
  logic signed [DEC_W-1:0] adv_tx;
  logic signed [DEC_W-1:0] adv_ty;

  // widened copies of the squared radii, their product and the last product
  assign asq_d  = signed'(DEC_W'(asq));
  assign bsq_d  = signed'(DEC_W'(bsq));
  assign ab_d   = signed'(DEC_W'(absq));
  assign prod_d = DEC_W'(prod);

  // multiplier operands
  assign y_ext   = {{(MUL_W - CB){y[CB-1]}}, y};
  assign y_m1    = y_ext - MUL_W'(1);
  assign twob_m1 = signed'(MUL_W'({rad_b, 1'b0}) - MUL_W'(1));
  assign twox_p1 = signed'(MUL_W'({x, 1'b1}));

  always_comb begin
    case (uop)
      U_ASQ: begin
        opa = signed'(MUL_W'(rad_a));
        opb = signed'(MUL_W'(rad_a));
      end
      U_BSQ: begin
        opa = signed'(MUL_W'(rad_b));
        opb = signed'(MUL_W'(rad_b));
      end
      U_T: begin
        opa = twob_m1;
        opb = twob_m1;
      end
      U_P, U_Q2: begin
        opa = signed'(MUL_W'(asq));
        opb = signed'(MUL_W'(tmp));
      end
      U_AB: begin
        opa = signed'(MUL_W'(asq));
        opb = signed'(MUL_W'(bsq));
      end
      U_TY: begin
        opa = signed'(MUL_W'(asq));
        opb = signed'(MUL_W'(rad_b));
      end
      U_S1: begin
        opa = twox_p1;
        opb = twox_p1;
      end
      U_Q1: begin
        opa = signed'(MUL_W'(bsq));
        opb = signed'(MUL_W'(tmp));
      end
      U_S2: begin
        opa = y_m1;
        opb = y_m1;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // region one test, scaled by four: 8a2*y - 4a2 > 8b2*x + 8b2
  assign lhs     = ty - (asq_d <<< 2);
  assign rhs     = tx + (bsq_d <<< 3);
  assign test_r1 = lhs > rhs;
  assign y_neg   = y[CB-1];

  // one midpoint advance, tx = 8b2*x and ty = 8a2*y kept incrementally
  assign x_inc  = x + CB'(1);
  assign y_dec  = y - CB'(1);
  assign tx_inc = tx + (bsq_d <<< 3);
  assign ty_dec = ty - (asq_d <<< 3);

  always_comb begin
    if (!r2) begin
      adv_x  = x_inc;
      adv_tx = tx_inc;
      if (d[DEC_W-1]) begin
        adv_y  = y;
        adv_ty = ty;
        adv_d  = d + tx_inc + (bsq_d <<< 2);
      end else begin
        adv_y  = y_dec;
        adv_ty = ty_dec;
        adv_d  = d - ty_dec + tx_inc + (bsq_d <<< 2);
      end
    end else begin
      adv_y  = y_dec;
      adv_ty = ty_dec;
      if (!d[DEC_W-1] && (d != '0)) begin
        adv_x  = x;
        adv_tx = tx;
        adv_d  = d + (asq_d <<< 2) - ty_dec;
      end else begin
        adv_x  = x_inc;
        adv_tx = tx_inc;
        adv_d  = d + tx_inc + (asq_d <<< 2) - ty_dec;
      end
    end
  end

  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign grp_valid = (state == ST_DELIVER);
  assign grp       = gctl;
  assign grp_cx    = cx;
  assign grp_cy    = cy;
  assign grp_x     = gx;
  assign grp_y     = gy;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      uop       <= U_ASQ;
      from_step <= 1'b0;
      active    <= 1'b0;
      r2        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_op == mer_pkg::OP_START) begin
              cx        <= q_cx;
              cy        <= q_cy;
              rad_a     <= q_rx;
              rad_b     <= q_ry;
              uop       <= U_ASQ;
              from_step <= 1'b0;
              state     <= ST_MUL;
            end else if (active) begin
              gx        <= x;
              gy        <= y;
              x         <= adv_x;
              y         <= adv_y;
              d         <= adv_d;
              tx        <= adv_tx;
              ty        <= adv_ty;
              from_step <= 1'b1;
              state     <= ST_SETTLE;
            end else begin
              gctl  <= '{points: 1'b0, done: 1'b1};
              state <= ST_DELIVER;
            end
          end
        end
        ST_MUL: begin
          prod  <= opa * opb;
          state <= ST_WB;
        end
        ST_WB: begin
          state <= ST_MUL;
          case (uop)
            U_ASQ: begin
              asq <= prod[SQ_W-1:0];
              uop <= U_BSQ;
            end
            U_BSQ: begin
              bsq <= prod[SQ_W-1:0];
              uop <= U_T;
            end
            U_T: begin
              tmp <= prod[TMP_W-1:0];
              uop <= U_P;
            end
            U_P: begin
              d   <= prod_d;
              uop <= U_AB;
            end
            U_AB: begin
              absq <= prod[AB_W-1:0];
              d    <= d + (bsq_d <<< 2) - (prod_d <<< 2);
              uop  <= U_TY;
            end
            U_TY: begin
              ty     <= prod_d <<< 3;
              tx     <= '0;
              x      <= '0;
              y      <= signed'(CB'(rad_b));
              r2     <= 1'b0;
              active <= 1'b1;
              state  <= ST_SETTLE;
            end
            U_S1: begin
              tmp <= prod[TMP_W-1:0];
              uop <= U_Q1;
            end
            U_Q1: begin
              d   <= prod_d - (ab_d <<< 2);
              uop <= U_S2;
            end
            U_S2: begin
              tmp <= prod[TMP_W-1:0];
              uop <= U_Q2;
            end
            U_Q2: begin
              d     <= d + (prod_d <<< 2);
              state <= ST_SETTLE;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_SETTLE: begin
          if (active && !r2 && !test_r1) begin
            // leave region one: set up the region two decision
            r2    <= 1'b1;
            uop   <= U_S1;
            state <= ST_MUL;
          end else begin
            if (active && r2 && y_neg) begin
              active <= 1'b0;
            end
            gctl  <= '{points: 1'b1, done: !(active && !(r2 && y_neg))};
            state <= from_step ? ST_DELIVER : ST_IDLE;
          end
        end
        ST_DELIVER: begin
          if (grp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/mer_emit.sv]
// output stage: plays one result group out as mirrored points
`default_nettype none

module mer_emit #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         grp_valid,
  output logic                         grp_ready,
  input  mer_pkg::grp_t                grp,
  input  logic [COORD_BITS-1:0]        grp_cx,
  input  logic [COORD_BITS-1:0]        grp_cy,
  input  logic [COORD_BITS-1:0]        grp_x,
  input  logic signed [COORD_BITS-1:0] grp_y,
  mer_pix_if.source                    pix
);

  localparam int CB    = COORD_BITS;
  localparam int PIX_W = CB + 2;
  localparam int IDX_W = $clog2(mer_pkg::PTS_PER_STEP);

  logic                 busy;
  logic [IDX_W-1:0]     idx;
  mer_pkg::grp_t        ctl;
  logic [CB-1:0]        cx;
  logic [CB-1:0]        cy;
  logic [CB-1:0]        ox;
  logic signed [CB-1:0] oy;

  logic             last;
  logic             fire;
  logic             load;
  logic             neg_x;
  logic             neg_y;
  logic [PIX_W-1:0] cx_w;
  logic [PIX_W-1:0] cy_w;
  logic [PIX_W-1:0] ox_w;
  logic [PIX_W-1:0] oy_w;

  assign last      = !ctl.points || (idx == IDX_W'(mer_pkg::PTS_PER_STEP - 1));
  assign fire      = pix.valid && pix.ready;
  assign grp_ready = !busy || (fire && last);
  assign load      = grp_valid && grp_ready;

  // quadrant order: (+x,+y) (+x,-y) (-x,-y) (-x,+y)
  assign neg_x = idx[1];
  assign neg_y = idx[1] ^ idx[0];
  assign cx_w  = PIX_W'(cx);
  assign cy_w  = PIX_W'(cy);
  assign ox_w  = PIX_W'(ox);
  assign oy_w  = {{(PIX_W - CB){oy[CB-1]}}, oy};

  assign pix.valid       = busy;
  assign pix.pixel_valid = ctl.points;
  assign pix.run_last    = last;
  assign pix.curve_done  = ctl.done;
  assign pix.pixel_x     = !ctl.points ? '0 : (neg_x ? cx_w - ox_w : cx_w + ox_w);
  assign pix.pixel_y     = !ctl.points ? '0 : (neg_y ? cy_w - oy_w : cy_w + oy_w);

  // group payload
  always_ff @(posedge clk) begin
    if (load) begin
      ctl <= grp;
      cx  <= grp_cx;
      cy  <= grp_cy;
      ox  <= grp_x;
      oy  <= grp_y;
    end
  end

  // point sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fire) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/midpoint_ellipse_rasterizer_core.sv]
// top level of the midpoint ellipse rasterizer: front queue, decision back end, point emitter
// A step request is popped, settled and delivered, after region two setup if it enters region two.
// A start request holds the back end for the pop, six multiplies (each a multiply and a write-back
// state) and a settle, plus region two setup when the ellipse opens in region two; no result.
// The pixel port moves one point per cycle while pix.ready is high, four points per step.
// Reset (synchronous, active high) empties the queue and the emitter and leaves no ellipse active.
`default_nettype none

module midpoint_ellipse_rasterizer_core #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  mer_cmd_if.sink   cmd,
  mer_pix_if.source pix
);

  logic                         q_valid;
  logic                         q_pop;
  mer_pkg::op_t                 q_op;
  logic [COORD_BITS-1:0]        q_cx;
  logic [COORD_BITS-1:0]        q_cy;
  logic [COORD_BITS-2:0]        q_rx;
  logic [COORD_BITS-2:0]        q_ry;

  logic                         grp_valid;
  logic                         grp_ready;
  mer_pkg::grp_t                grp;
  logic [COORD_BITS-1:0]        grp_cx;
  logic [COORD_BITS-1:0]        grp_cy;
  logic [COORD_BITS-1:0]        grp_x;
  logic signed [COORD_BITS-1:0] grp_y;

  // request intake and queue
  mer_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .q_valid(q_valid),
    .q_pop  (q_pop),
    .q_op   (q_op),
    .q_cx   (q_cx),
    .q_cy   (q_cy),
    .q_rx   (q_rx),
    .q_ry   (q_ry)
  );

  // decision sequencer
  mer_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_op     (q_op),
    .q_cx     (q_cx),
    .q_cy     (q_cy),
    .q_rx     (q_rx),
    .q_ry     (q_ry),
    .grp_valid(grp_valid),
    .grp_ready(grp_ready),
    .grp      (grp),
    .grp_cx   (grp_cx),
    .grp_cy   (grp_cy),
    .grp_x    (grp_x),
    .grp_y    (grp_y)
  );

  // mirrored point output
  mer_emit #(
    .COORD_BITS(COORD_BITS)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .grp_valid(grp_valid),
    .grp_ready(grp_ready),
    .grp      (grp),
    .grp_cx   (grp_cx),
    .grp_cy   (grp_cy),
    .grp_x    (grp_x),
    .grp_y    (grp_y),
    .pix      (pix)
  );

  // a result without a point is always the lone finished marker
  a_idle_marker: assert property (@(posedge clk) disable iff (rst)
    pix.valid && !pix.pixel_valid |-> pix.run_last && pix.curve_done)
    else $error("point-less result is not a single done marker");

  // a group handed to the emitter shows up on the port next cycle
  a_group_shown: assert property (@(posedge clk) disable iff (rst)
    grp_valid && grp_ready |=> pix.valid)
    else $error("loaded group not presented on pixel port");

  // within a run of four points the run continues with the same done flag
  a_run_steady: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready && !pix.run_last |=>
      pix.valid && pix.pixel_valid && (pix.curve_done == $past(pix.curve_done)))
    else $error("point run broken or done flag changed mid-run");

endmodule

`default_nettype wire
